### rtl/windowed_flat_field_correction_macros.svh
// ----------------------------------------------------------------------------
// windowed flat-field correction assertion macros
// Concurrent check wrappers on clk and rst_n; define NO_ASSERTIONS to drop them.
// ----------------------------------------------------------------------------
`ifndef WINDOWED_FLAT_FIELD_CORRECTION_MACROS_SVH
`define WINDOWED_FLAT_FIELD_CORRECTION_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication, off during reset
`define WFFC_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wffc: same-cycle check failed");
// next-cycle implication, off during reset
`define WFFC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wffc: next-cycle check failed");
`else
`define WFFC_ASSERT_IMPLY(label, ante, cons)
`define WFFC_ASSERT_NEXT(label, ante, cons)
`endif
`endif

### rtl/wffc_pkg.sv
// ----------------------------------------------------------------------------
// wffc_pkg
// Shared types, widths and codes of the windowed flat-field correction engine.
// ----------------------------------------------------------------------------
package wffc_pkg;

    // default store geometry
    localparam int DEF_MAX_COLS = 512;
    localparam int DEF_MAX_ROWS = 512;

    // field widths
    localparam int DIM_W      = 10;
    localparam int WIN_W      = 9;
    localparam int FLAT_W     = 16;
    localparam int PIX_W      = 24;
    localparam int STATUS_W   = 2;
    localparam int FRAC_W     = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;

    // request kinds
    localparam logic REQ_LOAD    = 1'b0;
    localparam logic REQ_CORRECT = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_CORRECTED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_STORED    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_WIN_ERR   = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_COLS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_ROWS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_USE_WINDOW  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WIN_X_START = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WIN_Y_START = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_WIN_X_END   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_WIN_Y_END   = 3'd6;

    // request transaction payload
    typedef struct packed {
        logic                    req_type;
        logic [FLAT_W-1:0]       flat_in;
        logic signed [PIX_W-1:0] pixel_in;
    } wffc_req_t;

    // result transaction payload
    typedef struct packed {
        logic signed [PIX_W-1:0] pixel_out;
        logic [STATUS_W-1:0]     status;
        logic                    end_of_frame;
    } wffc_res_t;

endpackage

### rtl/wffc_if.sv
// ----------------------------------------------------------------------------
// wffc_if
// Valid/ready stream interfaces for request and result transactions.
// ----------------------------------------------------------------------------
interface wffc_req_if
    import wffc_pkg::*;
;
    logic      valid;
    logic      ready;
    wffc_req_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface wffc_res_if
    import wffc_pkg::*;
;
    logic      valid;
    logic      ready;
    wffc_res_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### rtl/windowed_flat_field_correction.sv
// ----------------------------------------------------------------------------
// windowed_flat_field_correction
// Flat-field engine: stores flat reciprocals, corrects image pixels by them.
// ----------------------------------------------------------------------------
// One transaction is in flight at a time. A correct transaction runs through
// setup, position, address multiply, flat memory read, pixel multiply and
// result register in turn; a rejected window goes from position straight to
// the result register. A load runs setup and position, then the reciprocal
// 2^24/flat comes from a restoring divider that retires one quotient bit per
// cycle, then the flat memory is written and the result registered; a zero
// flat skips the divider. The result register lets a new transaction start
// while the last result still waits downstream. The flat memory has no
// clearing pass and its entries hold no meaning until loaded.
`include "windowed_flat_field_correction_macros.svh"

module windowed_flat_field_correction
    import wffc_pkg::*;
#(
    parameter int MAX_COLS = DEF_MAX_COLS,
    parameter int MAX_ROWS = DEF_MAX_ROWS
)(
    input  logic                  clk,
    input  logic                  rst_n,
    wffc_req_if.sink              req_ch,
    wffc_res_if.source            res_ch,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int STORE_DEPTH = MAX_COLS * MAX_ROWS;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int POS_W       = 2 * DIM_W;
    localparam int EXT_W       = (ADDR_W > POS_W) ? ADDR_W : POS_W;
    localparam int NUM_W       = 25;
    localparam int CNT_W       = 5;
    localparam int MAG_W       = PIX_W - 1;
    localparam int PROD_W      = MAG_W + FLAT_W;
    localparam int SHR_W       = PROD_W + 1 - FRAC_W;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_PREP = 4'd1;
    localparam logic [3:0] S_POS  = 4'd2;
    localparam logic [3:0] S_ADDR = 4'd3;
    localparam logic [3:0] S_READ = 4'd4;
    localparam logic [3:0] S_MUL  = 4'd5;
    localparam logic [3:0] S_DIV  = 4'd6;
    localparam logic [3:0] S_WR   = 4'd7;
    localparam logic [3:0] S_OUT  = 4'd8;

    localparam logic [SHR_W-1:0]  PIX_MAX_V = SHR_W'(23'h7FFFFF);
    localparam logic [PROD_W:0]   ROUND_V   = (PROD_W+1)'(1) << (FRAC_W - 1);
    localparam logic [NUM_W-1:0]  ONE_Q     = NUM_W'(1) << FRAC_W;
    localparam logic [NUM_W-1:0]  DIV_TOP   = NUM_W'(1) << (NUM_W - 1);

    // configuration registers
    logic [DIM_W-1:0] frame_cols_reg;
    logic [DIM_W-1:0] frame_rows_reg;
    logic             use_window_reg;
    logic [WIN_W-1:0] win_x_start_reg;
    logic [WIN_W-1:0] win_y_start_reg;
    logic [WIN_W-1:0] win_x_end_reg;
    logic [WIN_W-1:0] win_y_end_reg;

    // sequencer and position state
    logic [3:0]       state_reg;
    logic [3:0]       state_next;
    logic [POS_W-1:0] load_pos_reg;
    logic [DIM_W-1:0] col_reg;
    logic [DIM_W-1:0] row_reg;

    // transaction payload
    logic                    req_type_reg;
    logic [FLAT_W-1:0]       flat_reg;
    logic signed [PIX_W-1:0] raw_reg;

    // geometry taken at setup
    logic [DIM_W-1:0] cols_reg;
    logic [DIM_W-1:0] bcols_reg;
    logic [DIM_W-1:0] brows_reg;
    logic [WIN_W-1:0] x0_reg;
    logic [WIN_W-1:0] y0_reg;
    logic             win_bad_reg;
    logic [POS_W-1:0] total_reg;

    // address path
    logic [DIM_W-1:0]  x_abs_reg;
    logic [DIM_W-1:0]  y_abs_reg;
    logic [ADDR_W-1:0] addr_reg;

    // divider
    logic [FLAT_W-1:0] rem_reg;
    logic [NUM_W-1:0]  num_reg;
    logic [CNT_W-1:0]  div_cnt_reg;

    // memory and product
    logic [FLAT_W-1:0] flat_mem [STORE_DEPTH];
    logic [FLAT_W-1:0] rd_data_reg;
    logic              mem_we;
    logic [FLAT_W-1:0] mem_wdata;
    logic [PROD_W-1:0] prod_reg;

    // result
    logic [STATUS_W-1:0]     res_status_reg;
    logic                    res_eof_reg;
    logic                    out_valid_reg;
    wffc_res_t               out_data_reg;
    logic signed [PIX_W-1:0] pix_result;

    // combinational helpers
    logic [DIM_W-1:0]  cols_eff;
    logic [DIM_W-1:0]  rows_eff;
    logic              win_bad_c;
    logic [DIM_W-1:0]  bcols_c;
    logic [DIM_W-1:0]  brows_c;
    logic [POS_W-1:0]  load_pos_fix;
    logic              load_last;
    logic              pos_stale;
    logic [DIM_W-1:0]  col_fix;
    logic [DIM_W-1:0]  row_fix;
    logic              col_last;
    logic              row_last;
    logic [POS_W-1:0]  addr_full;
    logic [EXT_W-1:0]  addr_ext;
    logic [EXT_W-1:0]  load_ext;
    logic [FLAT_W:0]   rem_shift;
    logic              div_ge;
    logic [FLAT_W:0]   rem_sub;
    logic [MAG_W-1:0]  raw_mag;
    logic [PROD_W:0]   prod_round;
    logic [SHR_W-1:0]  prod_shr;
    logic              raw_pos;
    logic              out_free;

    // handshakes
    assign req_ch.ready = (state_reg == S_IDLE);
    assign res_ch.valid = out_valid_reg;
    assign res_ch.data  = out_data_reg;
    assign out_free     = !out_valid_reg || res_ch.ready;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_cols_reg  <= DIM_W'(512);
            frame_rows_reg  <= DIM_W'(512);
            use_window_reg  <= 1'b0;
            win_x_start_reg <= '0;
            win_y_start_reg <= '0;
            win_x_end_reg   <= WIN_W'(511);
            win_y_end_reg   <= WIN_W'(511);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_FRAME_COLS:  frame_cols_reg  <= cfg_data[DIM_W-1:0];
                REG_FRAME_ROWS:  frame_rows_reg  <= cfg_data[DIM_W-1:0];
                REG_USE_WINDOW:  use_window_reg  <= cfg_data[0];
                REG_WIN_X_START: win_x_start_reg <= cfg_data[WIN_W-1:0];
                REG_WIN_Y_START: win_y_start_reg <= cfg_data[WIN_W-1:0];
                REG_WIN_X_END:   win_x_end_reg   <= cfg_data[WIN_W-1:0];
                REG_WIN_Y_END:   win_y_end_reg   <= cfg_data[WIN_W-1:0];
                default:         ;
            endcase
        end
    end

    // effective frame size and window check
    always_comb
    begin
        if (frame_cols_reg == '0)
            cols_eff = DIM_W'(1);
        else if (int'(frame_cols_reg) > MAX_COLS)
            cols_eff = DIM_W'(MAX_COLS);
        else
            cols_eff = frame_cols_reg;
        if (frame_rows_reg == '0)
            rows_eff = DIM_W'(1);
        else if (int'(frame_rows_reg) > MAX_ROWS)
            rows_eff = DIM_W'(MAX_ROWS);
        else
            rows_eff = frame_rows_reg;
        win_bad_c = use_window_reg &&
                    ({1'b0, win_x_end_reg} >= cols_eff ||
                     {1'b0, win_y_end_reg} >= rows_eff ||
                     win_x_start_reg > win_x_end_reg ||
                     win_y_start_reg > win_y_end_reg);
        if (use_window_reg)
        begin
            bcols_c = {1'b0, win_x_end_reg} - {1'b0, win_x_start_reg} + DIM_W'(1);
            brows_c = {1'b0, win_y_end_reg} - {1'b0, win_y_start_reg} + DIM_W'(1);
        end
        else
        begin
            bcols_c = cols_eff;
            brows_c = rows_eff;
        end
    end

    // position fix-up for stale counters
    always_comb
    begin
        load_pos_fix = (load_pos_reg >= total_reg) ? '0 : load_pos_reg;
        load_last    = (load_pos_fix == total_reg - POS_W'(1));
        pos_stale    = (col_reg >= bcols_reg) || (row_reg >= brows_reg);
        col_fix      = pos_stale ? '0 : col_reg;
        row_fix      = pos_stale ? '0 : row_reg;
        col_last     = (col_fix == bcols_reg - DIM_W'(1));
        row_last     = (row_fix == brows_reg - DIM_W'(1));
    end

    // address arithmetic
    assign addr_full = POS_W'(y_abs_reg) * POS_W'(cols_reg)
                       + {{(POS_W-DIM_W){1'b0}}, x_abs_reg};
    assign addr_ext  = EXT_W'(addr_full);
    assign load_ext  = EXT_W'(load_pos_fix);

    // one restoring division step
    assign rem_shift = {rem_reg, num_reg[NUM_W-1]};
    assign div_ge    = (rem_shift >= {1'b0, flat_reg});
    assign rem_sub   = rem_shift - {1'b0, flat_reg};

    // memory write data: saturated quotient
    assign mem_we    = (state_reg == S_WR);
    assign mem_wdata = (num_reg[NUM_W-1:FLAT_W] != '0) ? '1 : num_reg[FLAT_W-1:0];

    // rounding and clamping of the corrected pixel
    assign raw_mag    = raw_reg[MAG_W-1:0];
    assign raw_pos    = !raw_reg[PIX_W-1] && (raw_reg != '0);
    assign prod_round = {1'b0, prod_reg} + ROUND_V;
    assign prod_shr   = prod_round[PROD_W:FRAC_W];

    always_comb
    begin
        case (res_status_reg)
            ST_STORED:  pix_result = '0;
            ST_WIN_ERR: pix_result = raw_reg;
            default:
            begin
                if (!raw_pos)
                    pix_result = '0;
                else if (prod_shr > PIX_MAX_V)
                    pix_result = PIX_W'(PIX_MAX_V);
                else
                    pix_result = PIX_W'(prod_shr);
            end
        endcase
    end

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (req_ch.valid) state_next = S_PREP;
            S_PREP: state_next = S_POS;
            S_POS:
            begin
                if (req_type_reg == REQ_LOAD)
                    state_next = (flat_reg == '0) ? S_WR : S_DIV;
                else
                    state_next = win_bad_reg ? S_OUT : S_ADDR;
            end
            S_ADDR: state_next = S_READ;
            S_READ: state_next = S_MUL;
            S_MUL:  state_next = S_OUT;
            S_DIV:  if (div_cnt_reg == '0) state_next = S_WR;
            S_WR:   state_next = S_OUT;
            S_OUT:  if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            load_pos_reg  <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_POS)
            begin
                if (req_type_reg == REQ_LOAD)
                    load_pos_reg <= load_last ? '0 : load_pos_fix + POS_W'(1);
                else if (win_bad_reg)
                begin
                    col_reg <= '0;
                    row_reg <= '0;
                end
                else
                begin
                    col_reg <= col_last ? '0 : col_fix + DIM_W'(1);
                    if (col_last)
                        row_reg <= row_last ? '0 : row_fix + DIM_W'(1);
                    else
                        row_reg <= row_fix;
                end
            end
            if (state_reg == S_OUT && out_free)
                out_valid_reg <= 1'b1;
            else if (res_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        // capture request transaction
        if (state_reg == S_IDLE && req_ch.valid)
        begin
            req_type_reg <= req_ch.data.req_type;
            flat_reg     <= req_ch.data.flat_in;
            raw_reg      <= req_ch.data.pixel_in;
        end
        // geometry setup
        if (state_reg == S_PREP)
        begin
            cols_reg    <= cols_eff;
            bcols_reg   <= bcols_c;
            brows_reg   <= brows_c;
            x0_reg      <= use_window_reg ? win_x_start_reg : '0;
            y0_reg      <= use_window_reg ? win_y_start_reg : '0;
            win_bad_reg <= win_bad_c;
            total_reg   <= POS_W'(cols_eff) * POS_W'(rows_eff);
        end
        // position, divider start and early results
        if (state_reg == S_POS)
        begin
            if (req_type_reg == REQ_LOAD)
            begin
                addr_reg       <= load_ext[ADDR_W-1:0];
                rem_reg        <= '0;
                num_reg        <= (flat_reg == '0) ? ONE_Q
                                  : (DIV_TOP | NUM_W'(flat_reg >> 1));
                div_cnt_reg    <= CNT_W'(NUM_W - 1);
                res_status_reg <= ST_STORED;
                res_eof_reg    <= load_last;
            end
            else if (win_bad_reg)
            begin
                res_status_reg <= ST_WIN_ERR;
                res_eof_reg    <= 1'b0;
            end
            else
            begin
                x_abs_reg      <= {1'b0, x0_reg} + col_fix;
                y_abs_reg      <= {1'b0, y0_reg} + row_fix;
                res_status_reg <= ST_CORRECTED;
                res_eof_reg    <= col_last && row_last;
            end
        end
        // frame address
        if (state_reg == S_ADDR)
            addr_reg <= addr_ext[ADDR_W-1:0];
        // reciprocal, one quotient bit per cycle
        if (state_reg == S_DIV)
        begin
            rem_reg     <= div_ge ? rem_sub[FLAT_W-1:0] : rem_shift[FLAT_W-1:0];
            num_reg     <= {num_reg[NUM_W-2:0], div_ge};
            div_cnt_reg <= div_cnt_reg - CNT_W'(1);
        end
        // pixel times reciprocal
        if (state_reg == S_MUL)
            prod_reg <= PROD_W'(raw_mag) * PROD_W'(rd_data_reg);
        // result register
        if (state_reg == S_OUT && out_free)
        begin
            out_data_reg.pixel_out    <= pix_result;
            out_data_reg.status       <= res_status_reg;
            out_data_reg.end_of_frame <= res_eof_reg;
        end
    end

    // flat reciprocal memory with a registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
            flat_mem[addr_reg] <= mem_wdata;
        rd_data_reg <= flat_mem[addr_reg];
    end

    // checks
    `WFFC_ASSERT_NEXT(a_accept_starts_setup, req_ch.valid && req_ch.ready, state_reg == S_PREP)
    `WFFC_ASSERT_IMPLY(a_read_in_range, state_reg == S_READ, int'(addr_reg) < STORE_DEPTH)
    `WFFC_ASSERT_IMPLY(a_div_rem_below_flat, state_reg == S_WR && flat_reg != '0, rem_reg < flat_reg)
    `WFFC_ASSERT_NEXT(a_result_only_from_out, state_reg != S_OUT && !out_valid_reg, !out_valid_reg)

endmodule
